// ----- rtl/tdu_pkg.sv -----
// Package for the truncated double unpacker.
// Holds the keep-count constants, register indexes and the keep rule.
// No dependencies.
`timescale 1ns / 1ps

package tdu_pkg;

    localparam int unsigned LimitWidth    = 63;
    localparam int unsigned CountWidth    = 21;
    localparam int unsigned TotalWidth    = 24;
    localparam int unsigned ValueWidth    = 64;
    localparam int unsigned ByteWidth     = 8;
    localparam int unsigned CfgIndexWidth = 1;
    localparam int unsigned CfgDataWidth  = 64;
    localparam int unsigned CompareCount  = 6;

    localparam logic [CfgIndexWidth-1:0] CfgLimitBits  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgValueCount = 1'b1;

    localparam logic [3:0]  KeepShort = 4'd2;
    localparam logic [3:0]  KeepFull  = 4'd8;
    localparam logic [15:0] KLowFull  = 16'd16;
    localparam logic [15:0] KHighFull = 16'd64879;
    localparam logic [15:0] KGapLow   = 16'd32111;
    localparam logic [15:0] KGapHigh  = 16'd32784;

    localparam logic [CountWidth-1:0] CountReset = 21'd1;

    // Kept-byte count of a number from its top 16 bits. Each step raises the
    // magnitude by 256, which adds eight to the binary exponent.
    function automatic logic [3:0] keep_for(input logic [15:0] k,
                                            input logic [LimitWidth-1:0] limit);
        logic [63:0] mag;
        logic [63:0] raised;
        logic        run;
        logic [3:0]  skip;
        mag  = {1'b0, k[14:0], 48'b0};
        run  = 1'b1;
        skip = 4'd0;
        for (int i = 0; i < CompareCount; i++) begin
            raised = mag + ({58'b0, 6'(8 * i)} << 52);
            if (run && (raised < {1'b0, limit})) begin
                skip = skip + 4'd1;
            end
            else begin
                run = 1'b0;
            end
        end
        if (k == 16'd0) begin
            keep_for = KeepShort;
        end
        else if ((k < KLowFull) || (k > KHighFull) || ((k > KGapLow) && (k < KGapHigh))) begin
            keep_for = KeepFull;
        end
        else begin
            keep_for = KeepFull - skip;
        end
    endfunction

endpackage

// ----- rtl/truncated_double_unpacker.sv -----
// The result word appears in the cycle after the last kept byte of a number is accepted.
// One byte per cycle while in_ready is high; the keep count comes from six parallel compares.
// A result waiting in the output register does not stop input while out_ready is high.
// Reset (rst_n, asynchronous, active low) clears the stream position and the block counts,
// sets limit_bits to zero and value_count to one. Configuration is always ready.
`timescale 1ns / 1ps

module truncated_double_unpacker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tdu_pkg::ByteWidth-1:0]         packed_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tdu_pkg::ValueWidth-1:0]        value_bits,
    output logic [tdu_pkg::TotalWidth-1:0]        bytes_used,
    output logic                                  last_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tdu_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [tdu_pkg::CfgDataWidth-1:0]      cfg_data
);

    logic [tdu_pkg::LimitWidth-1:0] limit_reg;
    logic [tdu_pkg::CountWidth-1:0] count_reg;
    logic [2:0]                     pos_reg;
    logic [3:0]                     keep_reg;
    logic [tdu_pkg::ValueWidth-1:0] word_reg;
    logic [tdu_pkg::TotalWidth-1:0] total_reg;
    logic [tdu_pkg::CountWidth-1:0] done_reg;
    logic                           out_valid_reg;
    logic [tdu_pkg::ValueWidth-1:0] value_reg;
    logic [tdu_pkg::TotalWidth-1:0] bytes_reg;
    logic                           last_reg;

    logic                           accept;
    logic [tdu_pkg::ValueWidth-1:0] word_next;
    logic [tdu_pkg::TotalWidth-1:0] total_next;
    logic [tdu_pkg::CountWidth-1:0] done_next;
    logic [3:0]                     keep_next;
    logic                           emit;
    logic                           last_next;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign bytes_used = bytes_reg;
    assign last_value = last_reg;

    always_comb
    begin
        for (int lane = 0; lane < 8; lane++) begin
            if (pos_reg == 3'(lane)) begin
                word_next[63 - 8 * lane -: 8] = packed_byte;
            end
            else if ((pos_reg == 3'd0) || (3'(lane) > pos_reg)) begin
                word_next[63 - 8 * lane -: 8] = 8'd0;
            end
            else begin
                word_next[63 - 8 * lane -: 8] = word_reg[63 - 8 * lane -: 8];
            end
        end
        total_next = total_reg + 1'b1;
        done_next  = done_reg + 1'b1;
        last_next  = (done_next == count_reg);
        keep_next  = (pos_reg == 3'd1) ? tdu_pkg::keep_for(word_next[63:48], limit_reg)
                                       : keep_reg;
        emit       = (pos_reg != 3'd0) && (({1'b0, pos_reg} + 4'd1) >= keep_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg     <= '0;
            count_reg     <= tdu_pkg::CountReset;
            pos_reg       <= '0;
            keep_reg      <= tdu_pkg::KeepFull;
            total_reg     <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    tdu_pkg::CfgLimitBits:  limit_reg <= cfg_data[tdu_pkg::LimitWidth-1:0];
                    tdu_pkg::CfgValueCount: count_reg <= cfg_data[tdu_pkg::CountWidth-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                keep_reg <= keep_next;
                if (emit) begin
                    pos_reg       <= '0;
                    out_valid_reg <= 1'b1;
                    done_reg      <= last_next ? '0 : done_next;
                    total_reg     <= last_next ? '0 : total_next;
                end
                else begin
                    pos_reg   <= pos_reg + 3'd1;
                    total_reg <= total_next;
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                    end
                end
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            word_reg <= word_next;
            if (emit) begin
                value_reg <= word_next;
                bytes_reg <= total_next;
                last_reg  <= last_next;
            end
        end
    end

endmodule

// ----- rtl/tdu_checker.sv -----
// Port-level checker for the truncated double unpacker, bound to the top level.
// Depends on tdu_pkg for the field widths.
`timescale 1ns / 1ps

module tdu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [tdu_pkg::ValueWidth-1:0]    value_bits,
    input logic [tdu_pkg::TotalWidth-1:0]    bytes_used,
    input logic                              last_value
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_bits)
            && $stable(bytes_used) && $stable(last_value))
        else $error("stalled result word changed");

    // An empty output register never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

    // A new result word follows an accepted byte word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word without input");

    // A taken result word with no new input leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("result word repeated");

endmodule

bind truncated_double_unpacker tdu_checker u_tdu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_bits (value_bits),
    .bytes_used (bytes_used),
    .last_value (last_value)
);
